// ===== rtl/mandelbrot_escape_time_colorizer_assert.svh =====
// Assertion macros for the escape-time colorizer.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef MANDELBROT_ESCAPE_TIME_COLORIZER_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_COLORIZER_ASSERT_SVH

// Same-cycle implication.
`define METC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("colorizer check failed");

// Next-cycle implication.
`define METC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("colorizer check failed");

`endif

// ===== rtl/metc_pkg.sv =====
package metc_pkg;

    localparam int FRAC_BITS     = 28;
    localparam int MAX_DIM       = 4096;
    localparam int PALETTE_BANDS = 16;

    // |z|^2 bound of 4.0 in Q.28, on the 37-bit sum of squares
    localparam logic [36:0] ESCAPE_Q = 37'(4) << FRAC_BITS;

    localparam logic [31:0] REAL_ORIGIN_RST = 32'hD800_0000;   // -2.5
    localparam logic [31:0] IMAG_ORIGIN_RST = 32'hE000_0000;   // -2.0
    localparam logic [30:0] REAL_STEP_RST   = 31'h0010_0000;
    localparam logic [30:0] IMAG_STEP_RST   = 31'h0010_0000;
    localparam logic [15:0] ITER_LIMIT_RST  = 16'd200;

    // {red, green, blue}; last entry is the colour for points inside the set
    localparam logic [23:0] PALETTE [0:PALETTE_BANDS] = '{
        24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
        24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
        24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
        24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403,
        24'h101010
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_INIT,
        ST_SQUARE,
        ST_STEP
    } state_t;

    typedef enum logic [2:0] {
        REG_REAL_ORIGIN = 3'd0,
        REG_IMAG_ORIGIN = 3'd1,
        REG_REAL_STEP   = 3'd2,
        REG_IMAG_STEP   = 3'd3,
        REG_ITER_LIMIT  = 3'd4
    } reg_idx_t;

    // Saturate a 45-bit signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [44:0] v);
        logic [31:0] r;
        if (v > 45'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -45'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/mandelbrot_escape_time_colorizer.sv =====
// Each pixel passes through set-up (index * step products), init (c and z), then
// per iteration a square state (products through the shared multipliers) and a step
// state (update and escape test); a new pixel is taken only while the sequencer is idle.
// A finished result waits in the output register while the next pixel is taken.
// Reset (rst_n low, asynchronous): configuration returns to its reset values,
// the sequencer goes idle and the output register is emptied.
`include "mandelbrot_escape_time_colorizer_assert.svh"

module mandelbrot_escape_time_colorizer
(
    input  logic        clk,
    input  logic        rst_n,
    // pixel in: [11:0] column, [23:12] row
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // result out: [7:0] red, [15:8] green, [23:16] blue, [39:24] escape_count
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [31:0] real_origin_reg;
    logic [31:0] imag_origin_reg;
    logic [30:0] real_step_reg;
    logic [30:0] imag_step_reg;
    logic [15:0] iteration_limit_reg;
    logic        cfg_we;
    metc_pkg::reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = metc_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg     <= metc_pkg::REAL_ORIGIN_RST;
            imag_origin_reg     <= metc_pkg::IMAG_ORIGIN_RST;
            real_step_reg       <= metc_pkg::REAL_STEP_RST;
            imag_step_reg       <= metc_pkg::IMAG_STEP_RST;
            iteration_limit_reg <= metc_pkg::ITER_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            // addresses past the last register are dropped
            case (cfg_idx)
                metc_pkg::REG_REAL_ORIGIN: real_origin_reg     <= pwdata;
                metc_pkg::REG_IMAG_ORIGIN: imag_origin_reg     <= pwdata;
                metc_pkg::REG_REAL_STEP:   real_step_reg       <= pwdata[30:0];
                metc_pkg::REG_IMAG_STEP:   imag_step_reg       <= pwdata[30:0];
                metc_pkg::REG_ITER_LIMIT:  iteration_limit_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            metc_pkg::REG_REAL_ORIGIN: prdata = real_origin_reg;
            metc_pkg::REG_IMAG_ORIGIN: prdata = imag_origin_reg;
            metc_pkg::REG_REAL_STEP:   prdata = {1'b0, real_step_reg};
            metc_pkg::REG_IMAG_STEP:   prdata = {1'b0, imag_step_reg};
            metc_pkg::REG_ITER_LIMIT:  prdata = {16'd0, iteration_limit_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    metc_pkg::state_t state_reg, state_next;

    logic        in_xfer;
    logic        out_xfer;
    logic        go_on;        // current step iterates again
    logic        out_free;     // output register can take a result now
    logic        load_out;
    logic        sel_setup;    // multipliers take index * step operands

    assign in_xfer  = s_tvalid & s_tready;
    assign out_xfer = m_tvalid & m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            metc_pkg::ST_IDLE:   if (in_xfer) state_next = metc_pkg::ST_SETUP;
            metc_pkg::ST_SETUP:  state_next = metc_pkg::ST_INIT;
            metc_pkg::ST_INIT:   state_next = metc_pkg::ST_SQUARE;
            metc_pkg::ST_SQUARE: state_next = metc_pkg::ST_STEP;
            metc_pkg::ST_STEP:
            begin
                if (go_on)
                    state_next = metc_pkg::ST_SQUARE;
                else if (out_free)
                    state_next = metc_pkg::ST_IDLE;
            end
            default:             state_next = metc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready  = 1'b0;
        sel_setup = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            metc_pkg::ST_IDLE:  s_tready  = 1'b1;
            metc_pkg::ST_SETUP: sel_setup = 1'b1;
            metc_pkg::ST_STEP:  load_out  = ~go_on & out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= metc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Pixel indices, clamped to the image size
    // ------------------------------------------------------------------
    logic [11:0] col_in, row_in;
    logic [11:0] col_reg, row_reg;

    assign col_in = (32'(s_tdata[11:0]) >= metc_pkg::MAX_DIM) ?
                    12'(metc_pkg::MAX_DIM - 1) : s_tdata[11:0];
    assign row_in = (32'(s_tdata[23:12]) >= metc_pkg::MAX_DIM) ?
                    12'(metc_pkg::MAX_DIM - 1) : s_tdata[23:12];

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            col_reg <= col_in;
            row_reg <= row_in;
        end
    end

    // ------------------------------------------------------------------
    // Shared multipliers: index * step at set-up, then zx^2, zy^2, |zx*zy|
    // ------------------------------------------------------------------
    logic signed [32:0] zx_reg, zy_reg;
    logic [32:0] zx_neg, zy_neg;
    logic [31:0] mag_zx, mag_zy;
    logic [31:0] a0, b0, a1, b1, a2, b2;
    logic [63:0] p0_reg, p1_reg, p2_reg;
    logic        xy_neg_reg;

    assign zx_neg = -zx_reg;
    assign zy_neg = -zy_reg;
    assign mag_zx = zx_reg[32] ? zx_neg[31:0] : zx_reg[31:0];
    assign mag_zy = zy_reg[32] ? zy_neg[31:0] : zy_reg[31:0];

    always_comb
    begin
        if (sel_setup)
        begin
            a0 = {20'd0, col_reg};
            b0 = {1'b0, real_step_reg};
            a1 = {20'd0, row_reg};
            b1 = {1'b0, imag_step_reg};
            a2 = 32'd0;
            b2 = 32'd0;
        end
        else
        begin
            a0 = mag_zx;
            b0 = mag_zx;
            a1 = mag_zy;
            b1 = mag_zy;
            a2 = mag_zx;
            b2 = mag_zy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg inside {metc_pkg::ST_SETUP, metc_pkg::ST_SQUARE})
        begin
            p0_reg     <= 64'(a0) * 64'(b0);
            p1_reg     <= 64'(a1) * 64'(b1);
            p2_reg     <= 64'(a2) * 64'(b2);
            xy_neg_reg <= zx_reg[32] ^ zy_reg[32];
        end
    end

    // ------------------------------------------------------------------
    // c = origin + index * step, imaginary part snapped to zero below half a step
    // ------------------------------------------------------------------
    logic signed [44:0] cx_wide, cy_wide;
    logic [44:0] cy_neg;
    logic [44:0] cy_mag;
    logic        cy_snap;
    logic [31:0] cx_reg, cy_reg;

    assign cx_wide = $signed({{13{real_origin_reg[31]}}, real_origin_reg})
                   + $signed({2'b00, p0_reg[42:0]});
    assign cy_wide = $signed({{13{imag_origin_reg[31]}}, imag_origin_reg})
                   + $signed({2'b00, p1_reg[42:0]});
    assign cy_neg  = -cy_wide;
    assign cy_mag  = cy_wide[44] ? cy_neg : cy_wide;
    assign cy_snap = {cy_mag, 1'b0} < 46'(imag_step_reg);

    // ------------------------------------------------------------------
    // Iteration update: z <- z^2 + c
    // ------------------------------------------------------------------
    logic [35:0] sx, sy;
    logic [36:0] sum_sq;
    logic [15:0] count_reg;
    logic signed [37:0] nzx_w;
    logic [33:0] xy_q, xy_s;
    logic [33:0] nzy_w;

    assign sx     = p0_reg[63:metc_pkg::FRAC_BITS];
    assign sy     = p1_reg[63:metc_pkg::FRAC_BITS];
    assign sum_sq = {1'b0, sx} + {1'b0, sy};
    assign go_on  = (count_reg < iteration_limit_reg) && (sum_sq < metc_pkg::ESCAPE_Q);

    assign nzx_w = $signed({2'b00, sx}) - $signed({2'b00, sy})
                 + $signed({{6{cx_reg[31]}}, cx_reg});
    // 2*zx*zy in Q.28 is the product shifted by one bit less
    assign xy_q  = {2'b00, p2_reg[58:metc_pkg::FRAC_BITS - 1]};
    assign xy_s  = xy_neg_reg ? -xy_q : xy_q;
    assign nzy_w = xy_s + {{2{cy_reg[31]}}, cy_reg};

    always_ff @(posedge clk)
    begin
        case (state_reg)
            metc_pkg::ST_INIT:
            begin
                cx_reg    <= metc_pkg::sat32(cx_wide);
                cy_reg    <= cy_snap ? 32'd0 : metc_pkg::sat32(cy_wide);
                zx_reg    <= '0;
                zy_reg    <= '0;
                count_reg <= '0;
            end
            metc_pkg::ST_STEP:
            begin
                if (go_on)
                begin
                    zx_reg    <= nzx_w[32:0];
                    zy_reg    <= nzy_w[32:0];
                    count_reg <= count_reg + 16'd1;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Colour lookup and output register
    // ------------------------------------------------------------------
    logic [4:0]  pal_idx;
    logic [23:0] rgb;
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    assign out_free = ~m_tvalid_reg | m_tready;
    assign pal_idx  = (count_reg == iteration_limit_reg) ?
                      5'(metc_pkg::PALETTE_BANDS) : {1'b0, count_reg[3:0]};
    assign rgb      = metc_pkg::PALETTE[pal_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (load_out)
            m_tvalid_reg <= 1'b1;
        else if (out_xfer)
            m_tvalid_reg <= 1'b0;
    end

    // hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (load_out)
            m_tdata_reg <= {count_reg, rgb[7:0], rgb[15:8], rgb[23:16]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic step_now;
    logic out_at_limit;

    assign step_now     = (state_reg == metc_pkg::ST_STEP);
    assign out_at_limit = m_tvalid && (m_tdata[39:24] == iteration_limit_reg);

    `METC_ASSERT_NOW(a_ready_only_idle, s_tready, state_reg == metc_pkg::ST_IDLE)
    `METC_ASSERT_NOW(a_count_in_range, step_now, count_reg <= iteration_limit_reg)
    `METC_ASSERT_NOW(a_inside_is_dark, out_at_limit, m_tdata[23:0] == 24'h101010)
    `METC_ASSERT_NEXT(a_full_holds_step, step_now && !go_on && !out_free, step_now)

endmodule
